### design/assert_macros.svh
// Assertion macros for the bit field reader project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle.
`define BFR_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define BFR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`else

`define BFR_ASSERT_IMPLY(label, clk, rst, cond, prop, msg)
`define BFR_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

### design/bfr_pkg.sv
// Shared types, constants and helpers for the bit field reader.
`timescale 1ns / 1ps

package bfr_pkg;

  // FIFO geometry
  localparam int FIFO_DEPTH = 64;
  localparam int ADDR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Field widths
  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 7;
  localparam int OFFSET_W  = 3;
  localparam int VALUE_W   = 64;
  localparam int STATUS_W  = 2;
  localparam int AVAIL_W   = 10;
  localparam int SPAN_W    = 8;

  // Read window: a 64-bit field at offset 7 touches nine bytes
  localparam int WIN_BYTES = 9;
  localparam int BIDX_W    = 4;
  localparam int WIN_W     = WIN_BYTES * BYTE_W;

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 80;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_ALIGN = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_COUNT = 2'd1;
  localparam logic [STATUS_W-1:0] STS_SHORT     = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd3;

  localparam logic [COUNT_W-1:0] MAX_COUNT = 7'd64;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_MERGE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec_simple;
    logic fetch_start;
    logic fetch_step;
    logic finish_read;
  } bfr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic read_ok;
    logic fetch_done;
    logic out_free;
  } bfr_sts_t;

  // Advance a FIFO index by a small offset with wraparound
  function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] base,
                                                 input logic [BIDX_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + (ADDR_W+1)'(off);
    if (sum >= (ADDR_W+1)'(FIFO_DEPTH)) begin
      sum = sum - (ADDR_W+1)'(FIFO_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### design/bfr_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bfr_ctrl.sv
// Controller state machine for the bit field reader.
`timescale 1ns / 1ps

module bfr_ctrl import bfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  bfr_sts_t sts,
  output bfr_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.read_ok) begin
          state_next = ST_FETCH;
        end else if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        if (sts.fetch_done) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      ST_EXEC: begin
        cmd.fetch_start = sts.read_ok;
        cmd.exec_simple = !sts.read_ok && sts.out_free;
      end
      ST_FETCH: begin
        cmd.fetch_step = !sts.fetch_done;
      end
      ST_MERGE: begin
        cmd.finish_read = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### design/bfr_dp.sv
// Datapath for the bit field reader: byte FIFO, read window and result register.
`timescale 1ns / 1ps

module bfr_dp import bfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]      s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]  m_tuser,
  input  bfr_cmd_t             cmd,
  output bfr_sts_t             sts
);

  // Latched item
  logic [OP_W-1:0]     op_q;
  logic [BYTE_W-1:0]   byte_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic                clr_q;

  // FIFO control state
  logic [ADDR_W-1:0]   head, head_next;
  logic [ADDR_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]    fill, fill_next;
  logic [OFFSET_W-1:0] offset, offset_next;

  // Fetch state
  logic [BIDX_W-1:0]   issue_idx;
  logic [BIDX_W-1:0]   cap_idx;
  logic                rd_pend;
  logic [BYTE_W-1:0]   win [0:WIN_BYTES-1];

  // Result register
  logic                out_valid;
  logic [VALUE_W-1:0]  res_value;
  logic [STATUS_W-1:0] res_status;
  logic [AVAIL_W-1:0]  res_avail;

  // Combinational helpers
  logic [SPAN_W-1:0]   span;
  logic [BIDX_W-1:0]   need;
  logic [BIDX_W-1:0]   used;
  logic                cnt_valid;
  logic                full;
  logic                issue;
  logic                ram_we;
  logic [BYTE_W-1:0]   ram_rdata;
  logic [WIN_W-1:0]    win_flat;
  logic [WIN_W-1:0]    win_shift;
  logic [VALUE_W-1:0]  field_mask;
  logic [VALUE_W-1:0]  field_val;
  logic [STATUS_W-1:0] status_next;
  logic                load_res;

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= s_tuser;
      byte_q <= s_tdata[7:0];
      cnt_q  <= s_tdata[14:8];
      clr_q  <= s_tdata[15];
    end
  end

  // Span checks for a read
  assign span      = SPAN_W'(offset) + SPAN_W'(cnt_q);
  assign need      = BIDX_W'((span + SPAN_W'(7)) >> 3);
  assign used      = span[6:3];
  assign cnt_valid = (cnt_q != '0) && (cnt_q <= MAX_COUNT);
  assign full      = (fill == CNT_W'(FIFO_DEPTH));

  assign sts.read_ok    = (op_q == OP_READ) && cnt_valid && (fill >= CNT_W'(need));
  assign sts.fetch_done = (cap_idx == need);
  assign sts.out_free   = !out_valid || m_tready;

  // Byte store
  assign issue  = cmd.fetch_step && (issue_idx < need);
  assign ram_we = cmd.exec_simple && (op_q == OP_PUSH) && !full;

  bfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (byte_q),
    .re    (issue),
    .raddr (addr_add(head, issue_idx)),
    .rdata (ram_rdata)
  );

  // Issue reads and capture returning bytes into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      cap_idx   <= '0;
      rd_pend   <= 1'b0;
    end else if (cmd.fetch_start) begin
      issue_idx <= '0;
      cap_idx   <= '0;
      rd_pend   <= 1'b0;
    end else if (cmd.fetch_step) begin
      rd_pend <= issue;
      if (issue) issue_idx <= issue_idx + BIDX_W'(1);
      if (rd_pend) cap_idx <= cap_idx + BIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_step && rd_pend) begin
      win[cap_idx] <= ram_rdata;
    end
  end

  // Extract the field from the window
  always_comb begin
    for (int i = 0; i < WIN_BYTES; i++) begin
      win_flat[i*BYTE_W +: BYTE_W] = win[i];
    end
  end

  assign win_shift  = win_flat >> offset;
  assign field_mask = (cnt_q == MAX_COUNT) ? '1 :
                      ((VALUE_W'(1) << cnt_q[5:0]) - VALUE_W'(1));
  assign field_val  = win_shift[VALUE_W-1:0] & field_mask;

  // Apply the operation to the FIFO state
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    offset_next = offset;
    status_next = STS_OK;
    if (cmd.finish_read) begin
      head_next   = addr_add(head, used);
      fill_next   = fill - CNT_W'(used);
      offset_next = span[2:0];
    end else if (cmd.exec_simple) begin
      case (op_q)
        OP_PUSH: begin
          if (full) begin
            status_next = STS_FULL;
          end else begin
            tail_next = addr_add(tail, BIDX_W'(1));
            fill_next = fill + CNT_W'(1);
          end
        end
        OP_READ: begin
          status_next = cnt_valid ? STS_SHORT : STS_BAD_COUNT;
        end
        OP_ALIGN: begin
          if ((offset != '0) && (fill != '0)) begin
            head_next = addr_add(head, BIDX_W'(1));
            fill_next = fill - CNT_W'(1);
          end
          offset_next = '0;
        end
        OP_RESET: begin
          if (clr_q) begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
          end
          offset_next = '0;
        end
        default: begin
          status_next = STS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
      offset <= '0;
    end else begin
      head   <= head_next;
      tail   <= tail_next;
      fill   <= fill_next;
      offset <= offset_next;
    end
  end

  // Result register: hold until the transaction is taken
  assign load_res = cmd.exec_simple || cmd.finish_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_res) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_value  <= cmd.finish_read ? field_val : '0;
      res_status <= status_next;
      res_avail  <= AVAIL_W'(fill_next) << 3;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, res_avail, res_value};
  assign m_tuser  = res_status;

endmodule

### design/lsb_first_bit_field_reader.sv
// Top level of the LSB-first bit field reader.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid / s_tready  tdata: data_byte, bit_count, clear_buffer; tuser: op
//   m_*      out  m_tvalid / m_tready  tdata: field_value, available_bits; tuser: status
//
// One transaction is worked on at a time. Push, align, reset, query, spare ops
// and unservable reads load their result in EXEC once the output register is
// free. A servable read gathers the need bytes the field touches (up to nine)
// in FETCH: the byte store has one read port, so window bytes arrive one per
// cycle. The read loads its result in MERGE once the output register is free.
// A finished result sits in an output register; the next transaction is
// accepted while it waits, and only the write of the next result stalls. A
// reset op clears the bit offset, and empties the FIFO if clear_buffer is set.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lsb_first_bit_field_reader import bfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte, [14:8] bit_count, [15] clear_buffer
  input  logic [OP_W-1:0]      s_tuser,  // [2:0] op
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // [63:0] field_value, [73:64] available_bits, zero pad
  output logic [STATUS_W-1:0]  m_tuser   // [1:0] status
);

  bfr_cmd_t cmd;
  bfr_sts_t sts;

  logic       accept_in;
  logic       res_load;
  logic [3:0] step_cmds;

  bfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Collect the terms the checks look at
  assign accept_in = s_tvalid && s_tready;
  assign res_load  = cmd.exec_simple || cmd.finish_read;
  assign step_cmds = {cmd.exec_simple, cmd.fetch_start, cmd.finish_read, cmd.load_item};

  // One transaction in flight: acceptance closes the input side
  `BFR_ASSERT_NEXT(a_one_in_flight, clk, rst, accept_in, !s_tready, "accepted while busy")

  // A waiting result is never overwritten
  `BFR_ASSERT_IMPLY(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !res_load, "result overwritten")

  // At most one operation step per cycle
  `BFR_ASSERT_IMPLY(a_cmd_onehot, clk, rst, 1'b1, $onehot0(step_cmds), "conflicting commands")

  // Window fetch runs only while the input side is closed
  `BFR_ASSERT_IMPLY(a_fetch_busy, clk, rst, cmd.fetch_step, !s_tready, "fetch while accepting")

endmodule

### tb/sv/lsb_first_bit_field_reader_test.sv
// Self-checking testbench for the LSB-first bit field reader.
`timescale 1ns / 1ps

// Scoreboard: tracks the byte FIFO and bit offset, queues the expected result
// of every accepted transaction and compares returned results in order.
class bit_reader_scoreboard;
  logic [7:0] byte_mem [bfr_pkg::FIFO_DEPTH];
  int head_ptr;
  int tail_ptr;
  int held_bytes;
  int bit_pos;
  logic [63:0] want_value [$];
  logic [1:0]  want_status [$];
  logic [9:0]  want_avail [$];
  int errors;
  int results;
  int reads_ok;
  int reads_short;
  int bad_counts;
  int full_pushes;

  function new();
    head_ptr = 0;
    tail_ptr = 0;
    held_bytes = 0;
    bit_pos = 0;
    errors = 0;
    results = 0;
    reads_ok = 0;
    reads_short = 0;
    bad_counts = 0;
    full_pushes = 0;
  endfunction

  function int pending();
    return want_value.size();
  endfunction

  // Apply one accepted transaction and queue the result it should produce.
  function void note_accepted(logic [2:0] op, logic [7:0] data, logic [6:0] count,
                              logic clear);
    logic [63:0] value;
    logic [1:0]  status;
    logic [71:0] window;
    int span;
    int need;
    value = '0;
    status = bfr_pkg::STS_OK;
    window = '0;
    span = bit_pos + int'(count);
    need = (span + 7) / 8;
    case (op)
      bfr_pkg::OP_PUSH: begin
        if (held_bytes >= bfr_pkg::FIFO_DEPTH) begin
          status = bfr_pkg::STS_FULL;
          full_pushes++;
        end else begin
          byte_mem[tail_ptr] = data;
          tail_ptr = (tail_ptr + 1) % bfr_pkg::FIFO_DEPTH;
          held_bytes++;
        end
      end
      bfr_pkg::OP_READ: begin
        if (count == 0 || count > bfr_pkg::MAX_COUNT) begin
          status = bfr_pkg::STS_BAD_COUNT;
          bad_counts++;
        end else if (held_bytes < need) begin
          status = bfr_pkg::STS_SHORT;
          reads_short++;
        end else begin
          // gather the touched bytes, shift out the offset, mask to width
          for (int k = 0; k < need; k++) begin
            window[8*k +: 8] = byte_mem[(head_ptr + k) % bfr_pkg::FIFO_DEPTH];
          end
          window = window >> bit_pos;
          value = window[63:0];
          if (count < bfr_pkg::MAX_COUNT) begin
            value = value & ((64'd1 << count) - 64'd1);
          end
          for (int k = 0; k < span / 8; k++) begin
            head_ptr = (head_ptr + 1) % bfr_pkg::FIFO_DEPTH;
            held_bytes--;
          end
          bit_pos = span % 8;
          reads_ok++;
        end
      end
      bfr_pkg::OP_ALIGN: begin
        if (bit_pos > 0 && held_bytes > 0) begin
          head_ptr = (head_ptr + 1) % bfr_pkg::FIFO_DEPTH;
          held_bytes--;
        end
        bit_pos = 0;
      end
      bfr_pkg::OP_RESET: begin
        if (clear) begin
          head_ptr = 0;
          tail_ptr = 0;
          held_bytes = 0;
        end
        bit_pos = 0;
      end
      default: begin
      end
    endcase
    want_value.push_back(value);
    want_status.push_back(status);
    want_avail.push_back(10'(held_bytes * 8));
  endfunction

  // Compare one returned result with the oldest expectation.
  function void check_result(logic [63:0] value, logic [1:0] status, logic [9:0] avail);
    logic [63:0] exp_v;
    logic [1:0]  exp_s;
    logic [9:0]  exp_a;
    results++;
    if (want_value.size() == 0) begin
      $display("%0t: unexpected result value %h status %0d avail %0d",
               $time, value, status, avail);
      errors++;
      return;
    end
    exp_v = want_value.pop_front();
    exp_s = want_status.pop_front();
    exp_a = want_avail.pop_front();
    if (value !== exp_v) begin
      $display("%0t: field_value mismatch exp %h got %h", $time, exp_v, value);
      errors++;
    end
    if (status !== exp_s) begin
      $display("%0t: status mismatch exp %0d got %0d", $time, exp_s, status);
      errors++;
    end
    if (avail !== exp_a) begin
      $display("%0t: available_bits mismatch exp %0d got %0d", $time, exp_a, avail);
      errors++;
    end
  endfunction
endclass

module lsb_first_bit_field_reader_test;
  import bfr_pkg::*;

  localparam int OP_LAST     = 7;
  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_CYCLES = 300;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [OP_W-1:0]      s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]  m_tuser;

  bit_reader_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int sent;

  lsb_first_bit_field_reader dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Record accepted inputs, then check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_accepted(s_tuser, s_tdata[7:0], s_tdata[14:8], s_tdata[15]);
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata[63:0], m_tuser, m_tdata[73:64]);
      end
    end
  end

  // Result side: random backpressure, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (!quiet && $urandom_range(0, 99) < 15) begin
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offer one transaction and hold it until accepted. Enter and leave at negedge.
  task automatic issue(logic [2:0] op, logic [7:0] data, logic [6:0] count, logic clear);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {clear, count, data};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic wait_drain();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly well-formed traffic shaped by the current fill level, some noise.
  task automatic issue_random();
    int pick;
    int room;
    int count;
    pick = $urandom_range(0, 99);
    room = sb.held_bytes * 8 - sb.bit_pos;
    if (pick < 70 && (pick >= 30 || sb.held_bytes >= 60) && room > 0) begin
      count = $urandom_range(1, (room < 64) ? room : 64);
      if (room >= 64 && $urandom_range(0, 4) == 0) count = 64;
      issue(OP_READ, 8'($urandom), 7'(count), 1'($urandom));
    end else if (pick < 70) begin
      issue(OP_PUSH, 8'($urandom), 7'($urandom), 1'($urandom));
    end else if (pick < 78) begin
      issue(OP_ALIGN, 8'($urandom), 7'($urandom), 1'($urandom));
    end else if (pick < 84) begin
      issue(3'($urandom_range(OP_QUERY, OP_LAST)), 8'($urandom), 7'($urandom),
            1'($urandom));
    end else if (pick < 88) begin
      issue(OP_RESET, 8'($urandom), 7'($urandom), $urandom_range(0, 99) < 40);
    end else begin
      issue(3'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: bad counts, short data, aligns, resets, wide reads, spare ops.
    issue(OP_QUERY, 8'($urandom), 7'($urandom), 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd0, 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd65, 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd127, 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd1, 1'($urandom));
    issue(OP_ALIGN, 8'($urandom), 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'hFF, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'h00, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'h5A, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'hC3, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'h81, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'h7E, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'hFF, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'h01, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'h80, 7'($urandom), 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd7, 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd64, 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd2, 1'($urandom));
    issue(OP_ALIGN, 8'($urandom), 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'h3C, 7'($urandom), 1'($urandom));
    issue(OP_PUSH, 8'hA5, 7'($urandom), 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd3, 1'($urandom));
    issue(OP_RESET, 8'($urandom), 7'($urandom), 1'b0);
    issue(OP_ALIGN, 8'($urandom), 7'($urandom), 1'($urandom));
    issue(OP_READ, 8'($urandom), 7'd16, 1'($urandom));
    issue(OP_PUSH, 8'h96, 7'($urandom), 1'($urandom));
    issue(OP_RESET, 8'($urandom), 7'($urandom), 1'b1);
    for (int c = OP_QUERY + 1; c <= OP_LAST; c++) begin
      issue(3'(c), 8'($urandom), 7'($urandom), 1'($urandom));
    end
    wait_drain();

    // Random traffic with a quiet stretch, a full FIFO, a long stall and a pause.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 80) quiet = 1'b1;
      if (i == 140) quiet = 1'b0;
      if (i == 180) begin
        while (sb.held_bytes < FIFO_DEPTH) begin
          issue(OP_PUSH, 8'($urandom), 7'($urandom), 1'($urandom));
        end
        repeat (3) issue(OP_PUSH, 8'($urandom), 7'($urandom), 1'($urandom));
      end
      if (i == 240) begin
        hold_req = 1'b1;
        quiet = 1'b1;
      end
      if (i == 280) quiet = 1'b0;
      if (i == 320) wait_drain();
      issue_random();
    end
    wait_drain();
    repeat (20) @(posedge clk);

    sb.errors += sb.pending();
    $display("Covered %0d transactions, %0d results: %0d good reads, %0d short reads,",
             sent, sb.results, sb.reads_ok, sb.reads_short);
    $display("%0d bad bit counts, %0d pushes into a full FIFO.", sb.bad_counts,
             sb.full_pushes);
    if (sb.errors == 0) begin
      $display("** lsb_first_bit_field_reader: PASSED **");
    end else begin
      $display("** lsb_first_bit_field_reader: FAILED **");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #200000;
    $display("Timeout after %0t", $time);
    $display("** lsb_first_bit_field_reader: FAILED **");
    $finish;
  end

endmodule
